@@ design/satar_pkg.sv @@
package satar_pkg;

  // Stored entry layout.
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [7:0]  genbyte;
  } entry_t;

  typedef enum logic {
    MODE_PROBE = 1'b0,
    MODE_SAVE  = 1'b1
  } mode_e;

  localparam logic [1:0] EXACT_BOUND = 2'd3;
  localparam logic [7:0] GEN_MASK    = 8'hF8;
  localparam logic [8:0] GEN_CYCLE   = 9'd263;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic        mode;
    logic [63:0] key;
    logic [1:0]  slot;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic        pv;
  } req_t;

  // Result item.
  typedef struct packed {
    logic        hit;
    logic [1:0]  slot;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic        pv;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WRITE
  } state_e;

endpackage

@@ design/satar_front.sv @@
module satar_front
  import satar_pkg::*;
#(
  parameter int DEPTH_BIAS = -7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [63:0] search_key_i,
  input  logic [1:0]  slot_i,
  input  logic [15:0] new_value_i,
  input  logic [15:0] new_eval_i,
  input  logic [15:0] new_move_i,
  input  logic [8:0]  new_depth_i,
  input  logic [1:0]  new_bound_i,
  input  logic        new_pv_i,
  output logic        req_valid_o,
  output req_t        req_o,
  input  logic        req_take_i
);

  localparam int DLO = DEPTH_BIAS + 1;
  localparam int DHI = DEPTH_BIAS + 255;

  logic [1:0] cnt_q, cnt_d;
  req_t       buf_q [2];
  logic       rd_q, wr_q;
  req_t       req_new;
  logic       acc;
  logic [9:0] dext;
  logic [9:0] dsat;

  // Saturate the depth and remove the bias.
  always_comb begin
    dext = {new_depth_i[8], new_depth_i};
    if ($signed(dext) < $signed(10'(DLO))) begin
      dsat = 10'(DLO);
    end else if ($signed(dext) > $signed(10'(DHI))) begin
      dsat = 10'(DHI);
    end else begin
      dsat = dext;
    end
    req_new       = '0;
    req_new.mode  = mode_i;
    req_new.key   = search_key_i;
    req_new.slot  = slot_i;
    req_new.value = new_value_i;
    req_new.eval  = new_eval_i;
    req_new.move  = new_move_i;
    req_new.depth = 8'(dsat - 10'(DEPTH_BIAS));
    req_new.bound = new_bound_i;
    req_new.pv    = new_pv_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign acc         = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (acc && !(req_take_i && req_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!acc && req_take_i && req_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Two-entry request queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        wr_q <= !wr_q;
      end
      if (req_take_i && req_valid_o) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q[wr_q] <= req_new;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !req_valid_o)
    else $error("valid with empty queue");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (rd_q == wr_q))
    else $error("queue pointers inconsistent");

endmodule

@@ design/satar_back.sv @@
module satar_back
  import satar_pkg::*;
#(
  parameter int WAYS     = 3,
  parameter int CLUSTERS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] gen_i,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       req_take_o,
  output logic       busy_o,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       res_take_i
);

  localparam int CW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  state_e state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [CW-1:0] idx;
  logic [CW:0]   idx_full;
  logic [WAYS*$bits(entry_t)-1:0] mem [CLUSTERS];
  entry_t rd_q [WAYS];
  req_t   cur_q;
  logic [CW-1:0] cidx_q;
  logic   wen;
  logic [CW-1:0] waddr;
  logic [WAYS*$bits(entry_t)-1:0] wdata;
  entry_t nw [WAYS];
  res_t   res_d, res_q;
  logic   resv_q;
  logic   load_res;
  logic [CW+63:0] prod;

  // Cluster index is the top bits of key * CLUSTERS.
  assign prod     = req_i.key * (CW+64)'(CLUSTERS);
  assign idx_full = {1'b0, prod[CW+63:64]};
  assign idx      = (idx_full >= (CW+1)'(CLUSTERS)) ? CW'(CLUSTERS - 1) : idx_full[CW-1:0];

  function automatic logic signed [9:0] score(entry_t e, logic [7:0] g);
    logic [8:0] a;
    begin
      a = (GEN_CYCLE + {1'b0, g} - {1'b0, e.genbyte}) & {1'b0, GEN_MASK};
      score = $signed({2'b0, e.depth}) - $signed({1'b0, a});
    end
  endfunction

  // Decide the result and the updated cluster.
  always_comb begin
    logic found;
    logic [WW-1:0] fw;
    logic [WW-1:0] vic;
    logic [7:0] g;
    logic differ;
    entry_t e;
    found = 1'b0;
    fw    = '0;
    vic   = '0;
    g     = gen_i & GEN_MASK;
    differ = 1'b0;
    e     = '0;
    for (int i = 0; i < WAYS; i++) begin
      nw[i] = rd_q[i];
    end
    res_d = '0;
    res_d.slot = cur_q.slot;
    if (cur_q.mode == MODE_PROBE) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (rd_q[i].key == cur_q.key || rd_q[i].depth == 8'd0) begin
          found = 1'b1;
          fw    = WW'(i);
        end
      end
      for (int i = 1; i < WAYS; i++) begin
        if (score(rd_q[vic], g) > score(rd_q[i], g)) begin
          vic = WW'(i);
        end
      end
      if (found) begin
        nw[fw].genbyte = g | (rd_q[fw].genbyte & 8'h07);
        e = nw[fw];
        res_d.hit  = (e.depth != 8'd0);
        res_d.slot = 2'(fw);
      end else begin
        e = rd_q[vic];
        res_d.slot = 2'(vic);
      end
    end else if ({30'd0, cur_q.slot} < WAYS) begin
      e = rd_q[cur_q.slot[WW-1:0]];
      differ = (e.key != cur_q.key);
      if (cur_q.move != 16'd0 || differ) begin
        e.move = cur_q.move;
      end
      // A PV save is held to a two-ply penalty against the stored depth.
      if (cur_q.bound == EXACT_BOUND || differ ||
          ($signed({2'b00, cur_q.depth}) - $signed({8'd0, cur_q.pv, 1'b0})) >=
          $signed({2'b00, e.depth})) begin
        e.key     = cur_q.key;
        e.depth   = cur_q.depth;
        e.genbyte = g | {5'd0, cur_q.pv, cur_q.bound};
        e.value   = cur_q.value;
        e.eval    = cur_q.eval;
      end
      nw[cur_q.slot[WW-1:0]] = e;
    end
    if (cur_q.mode == MODE_PROBE || {30'd0, cur_q.slot} < WAYS) begin
      res_d.value = e.value;
      res_d.eval  = e.eval;
      res_d.move  = e.move;
      res_d.depth = e.depth;
      res_d.bound = e.genbyte[1:0];
      res_d.pv    = e.genbyte[2];
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      wdata[i*$bits(entry_t) +: $bits(entry_t)] = (state_q == ST_CLEAR) ? '0 : nw[i];
    end
  end

  // Sequencer: clear sweep, then read / write per item.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    req_take_o = 1'b0;
    wen        = 1'b0;
    waddr      = cidx_q;
    load_res   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wen   = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(CLUSTERS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i && !resv_q) begin
          req_take_o = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        wen      = 1'b1;
        load_res = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      resv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load_res) begin
        resv_q <= 1'b1;
      end else if (res_take_i) begin
        resv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      cur_q  <= req_i;
      cidx_q <= idx;
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

  // Cluster memory.
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (req_take_o) begin
      for (int i = 0; i < WAYS; i++) begin
        rd_q[i] <= mem[idx][i*$bits(entry_t) +: $bits(entry_t)];
      end
    end
  end

  assign res_valid_o = resv_q;
  assign res_o       = res_q;
  assign busy_o      = (state_q != ST_IDLE) || req_valid_i || resv_q;

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take_o |-> (state_q == ST_IDLE && !resv_q))
    else $error("request taken while busy");
  a_write_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> resv_q)
    else $error("result not posted");
  a_read_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_WRITE))
    else $error("read not followed by write");

endmodule

@@ design/set_assoc_table_age_replace_top.sv @@
// Channel | Direction | Handshake          | Payload
// input   | in        | push / full        | mode_i .. new_pv_i
// result  | out       | pop / empty        | hit_o .. out_pv_o
// config  | in        | cfg_valid/cfg_ready| cfg_data_i (generation)
// Each item passes through queue, cluster read, update and writeback in turn,
// as the single-port cluster memory is read and then written back. After
// reset a clearing pass zeroes the memory; items wait in the two-entry queue
// meanwhile. A result that is not popped holds the back end; the queue keeps
// taking items until it is full.
module set_assoc_table_age_replace_top
  import satar_pkg::*;
#(
  parameter int WAYS       = 3,
  parameter int CLUSTERS   = 1024,
  parameter int DEPTH_BIAS = -7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [63:0] search_key_i,
  input  logic [1:0]  slot_i,
  input  logic [15:0] new_value_i,
  input  logic [15:0] new_eval_i,
  input  logic [15:0] new_move_i,
  input  logic [8:0]  new_depth_i,
  input  logic [1:0]  new_bound_i,
  input  logic        new_pv_i,
  output logic        empty,
  input  logic        pop,
  output logic        hit_o,
  output logic [1:0]  slot_out_o,
  output logic [15:0] out_value_o,
  output logic [15:0] out_eval_o,
  output logic [15:0] out_move_o,
  output logic [7:0]  out_depth_o,
  output logic [1:0]  out_bound_o,
  output logic        out_pv_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] gen_q;
  logic       req_valid, req_take, busy, res_valid;
  req_t       req;
  res_t       res;

  // Generation register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cfg_valid) begin
      gen_q <= cfg_data_i;
    end
  end

  satar_front #(.DEPTH_BIAS(DEPTH_BIAS)) u_front (
    .clk_i, .rst_ni, .push, .full, .mode_i, .search_key_i, .slot_i,
    .new_value_i, .new_eval_i, .new_move_i, .new_depth_i, .new_bound_i,
    .new_pv_i, .req_valid_o(req_valid), .req_o(req), .req_take_i(req_take)
  );

  satar_back #(.WAYS(WAYS), .CLUSTERS(CLUSTERS)) u_back (
    .clk_i, .rst_ni, .gen_i(gen_q), .req_valid_i(req_valid), .req_i(req),
    .req_take_o(req_take), .busy_o(busy), .res_valid_o(res_valid),
    .res_o(res), .res_take_i(pop && !empty)
  );

  assign empty       = !res_valid;
  assign hit_o       = res.hit;
  assign slot_out_o  = res.slot;
  assign out_value_o = res.value;
  assign out_eval_o  = res.eval;
  assign out_move_o  = res.move;
  assign out_depth_o = res.depth;
  assign out_bound_o = res.bound;
  assign out_pv_o    = res.pv;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> busy)
    else $error("result pending but back end idle");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) |=> (empty || $past(busy)))
    else $error("pop inconsistency");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> req_valid)
    else $error("full without queued request");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import satar_pkg::*;

  localparam int WAYS       = 3;
  localparam int CLUSTERS   = 1024;
  localparam int DEPTH_BIAS = -7;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        mode_i;
  logic [63:0] search_key_i;
  logic [1:0]  slot_i;
  logic [15:0] new_value_i;
  logic [15:0] new_eval_i;
  logic [15:0] new_move_i;
  logic [8:0]  new_depth_i;
  logic [1:0]  new_bound_i;
  logic        new_pv_i;
  logic        empty;
  logic        pop;
  logic        hit_o;
  logic [1:0]  slot_out_o;
  logic [15:0] out_value_o;
  logic [15:0] out_eval_o;
  logic [15:0] out_move_o;
  logic [7:0]  out_depth_o;
  logic [1:0]  out_bound_o;
  logic        out_pv_o;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data_i;

  set_assoc_table_age_replace_top #(
    .WAYS      (WAYS),
    .CLUSTERS  (CLUSTERS),
    .DEPTH_BIAS(DEPTH_BIAS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .search_key_i(search_key_i),
    .slot_i      (slot_i),
    .new_value_i (new_value_i),
    .new_eval_i  (new_eval_i),
    .new_move_i  (new_move_i),
    .new_depth_i (new_depth_i),
    .new_bound_i (new_bound_i),
    .new_pv_i    (new_pv_i),
    .empty       (empty),
    .pop         (pop),
    .hit_o       (hit_o),
    .slot_out_o  (slot_out_o),
    .out_value_o (out_value_o),
    .out_eval_o  (out_eval_o),
    .out_move_o  (out_move_o),
    .out_depth_o (out_depth_o),
    .out_bound_o (out_bound_o),
    .out_pv_o    (out_pv_o),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data_i  (cfg_data_i)
  );

  // One table request as it goes onto the input ports.
  typedef struct {
    mode_e       mode;
    logic [63:0] key;
    logic [1:0]  slot;
    logic [15:0] value;
    logic [15:0] eval;
    logic [15:0] move;
    logic [8:0]  depth;
    logic [1:0]  bound;
    logic        pv;
  } request_t;

  // Directed row: a request plus an optional hand-typed answer.
  typedef struct {
    request_t req;
    bit       fixed;
    res_t     answer;
  } row_t;

  // Shadow copy of the table and the generation register.
  entry_t      shadow_table [WAYS*CLUSTERS];
  logic [7:0]  shadow_gen;
  res_t        pending_results[$];
  res_t        typed_answers[$];
  bit          typed_valid[$];
  int          error_count;

  // Idle and stall percentages, plus the long stall request.
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  // Keys used for the random part: a small pool sharing few clusters.
  logic [63:0] key_pool[16];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Limit on the whole run.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int cluster_index(logic [63:0] key);
    logic [127:0] prod;
    int           idx;
    prod = key * 128'(CLUSTERS);
    idx  = int'(prod[127:64]);
    if (idx >= CLUSTERS) idx = CLUSTERS - 1;
    return idx;
  endfunction

  function automatic int age_score(entry_t e, logic [7:0] gen);
    logic [8:0] age;
    age = (GEN_CYCLE + 9'(gen) - 9'(e.genbyte)) & 9'h0F8;
    return int'(e.depth) - int'(age);
  endfunction

  function automatic res_t result_of(bit hit, logic [1:0] way, entry_t e);
    res_t r;
    r.hit   = hit;
    r.slot  = way;
    r.value = e.value;
    r.eval  = e.eval;
    r.move  = e.move;
    r.depth = e.depth;
    r.bound = e.genbyte[1:0];
    r.pv    = e.genbyte[2];
    return r;
  endfunction

  // Predict the result of one request and update the shadow table.
  function automatic res_t predict_table(request_t q);
    int         base;
    int         victim;
    int         d;
    logic [7:0] gen;
    bit         differ;
    entry_t     e;
    res_t       r;
    base = cluster_index(q.key) * WAYS;
    gen  = shadow_gen & GEN_MASK;
    if (q.mode == MODE_PROBE) begin
      for (int i = 0; i < WAYS; i++) begin
        e = shadow_table[base+i];
        if (e.key == q.key || e.depth == 8'd0) begin
          e.genbyte = gen | (e.genbyte & 8'h07);
          shadow_table[base+i] = e;
          return result_of(e.depth != 8'd0, 2'(i), e);
        end
      end
      victim = 0;
      for (int i = 1; i < WAYS; i++)
        if (age_score(shadow_table[base+victim], gen) >
            age_score(shadow_table[base+i], gen))
          victim = i;
      return result_of(1'b0, 2'(victim), shadow_table[base+victim]);
    end
    if (int'(q.slot) >= WAYS) begin
      r = '0;
      r.slot = q.slot;
      return r;
    end
    d = $signed(q.depth);
    if (d < DEPTH_BIAS + 1)   d = DEPTH_BIAS + 1;
    if (d > DEPTH_BIAS + 255) d = DEPTH_BIAS + 255;
    e = shadow_table[base+q.slot];
    differ = (e.key != q.key);
    if (q.move != 16'd0 || differ) e.move = q.move;
    if (q.bound == EXACT_BOUND || differ ||
        d - DEPTH_BIAS - 2 * int'(q.pv) >= int'(e.depth)) begin
      e.key     = q.key;
      e.depth   = 8'(d - DEPTH_BIAS);
      e.genbyte = gen | {5'd0, q.pv, q.bound};
      e.value   = q.value;
      e.eval    = q.eval;
    end
    shadow_table[base+q.slot] = e;
    return result_of(1'b0, q.slot, e);
  endfunction

  // Offer one request until it is taken, idling first at random.
  // Push stays high after the transfer until the next call decides.
  task automatic send_request(request_t q);
    if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct);
    end
    push         <= 1'b1;
    mode_i       <= q.mode;
    search_key_i <= q.key;
    slot_i       <= q.slot;
    new_value_i  <= q.value;
    new_eval_i   <= q.eval;
    new_move_i   <= q.move;
    new_depth_i  <= q.depth;
    new_bound_i  <= q.bound;
    new_pv_i     <= q.pv;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_checked(request_t q, bit fixed, res_t answer);
    pending_results.push_back(predict_table(q));
    typed_valid.push_back(fixed);
    typed_answers.push_back(answer);
    send_request(q);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_generation(logic [7:0] gen);
    cfg_valid  <= 1'b1;
    cfg_data_i <= gen;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    shadow_gen = gen;
  endtask

  function automatic request_t random_request();
    request_t q;
    q.mode  = ($urandom_range(99, 0) < 55) ? MODE_SAVE : MODE_PROBE;
    q.key   = ($urandom_range(9, 0) == 0) ? {$urandom, $urandom} :
              key_pool[$urandom_range(15, 0)];
    q.slot  = ($urandom_range(9, 0) == 0) ? 2'd3 : 2'($urandom_range(WAYS - 1, 0));
    q.value = 16'($urandom);
    q.eval  = 16'($urandom);
    q.move  = ($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(5, 0))
      0:       q.depth = 9'($urandom);
      1:       q.depth = 9'($signed(-$urandom_range(256, 6)));
      default: q.depth = 9'($urandom_range(40, 0));
    endcase
    q.bound = 2'($urandom);
    q.pv    = 1'($urandom);
    return q;
  endfunction

  function automatic request_t make_req(mode_e m, logic [63:0] k, logic [1:0] s,
                                        logic [15:0] v, logic [15:0] ev, logic [15:0] mv,
                                        logic [8:0] d, logic [1:0] b, logic p);
    request_t q;
    q.mode = m; q.key = k; q.slot = s; q.value = v; q.eval = ev;
    q.move = mv; q.depth = d; q.bound = b; q.pv = p;
    return q;
  endfunction

  function automatic res_t make_res(logic h, logic [1:0] s, logic [15:0] v, logic [15:0] ev,
                                    logic [15:0] mv, logic [7:0] d, logic [1:0] b, logic p);
    res_t r;
    r.hit = h; r.slot = s; r.value = v; r.eval = ev;
    r.move = mv; r.depth = d; r.bound = b; r.pv = p;
    return r;
  endfunction

  // Result side: random stalls, a long hold-off on request, and checking.
  initial begin
    res_t exp_res;
    res_t got;
    res_t typed;
    bit   fixed;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      pop <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      @(posedge clk_i);
      if (pop && !empty) begin
        got = make_res(hit_o, slot_out_o, out_value_o, out_eval_o, out_move_o,
                       out_depth_o, out_bound_o, out_pv_o);
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          typed   = typed_answers.pop_front();
          fixed   = typed_valid.pop_front();
          if (fixed && typed != exp_res) begin
            $error("typed answer %p differs from prediction %p", typed, exp_res);
            error_count++;
          end
          if (got.hit !== exp_res.hit) begin
            $error("hit: expected %0h, got %0h", exp_res.hit, got.hit);
            error_count++;
          end
          if (got.slot !== exp_res.slot) begin
            $error("slot_out: expected %0h, got %0h", exp_res.slot, got.slot);
            error_count++;
          end
          if (got.value !== exp_res.value) begin
            $error("out_value: expected %0h, got %0h", exp_res.value, got.value);
            error_count++;
          end
          if (got.eval !== exp_res.eval) begin
            $error("out_eval: expected %0h, got %0h", exp_res.eval, got.eval);
            error_count++;
          end
          if (got.move !== exp_res.move) begin
            $error("out_move: expected %0h, got %0h", exp_res.move, got.move);
            error_count++;
          end
          if (got.depth !== exp_res.depth) begin
            $error("out_depth: expected %0h, got %0h", exp_res.depth, got.depth);
            error_count++;
          end
          if (got.bound !== exp_res.bound) begin
            $error("out_bound: expected %0h, got %0h", exp_res.bound, got.bound);
            error_count++;
          end
          if (got.pv !== exp_res.pv) begin
            $error("out_pv: expected %0h, got %0h", exp_res.pv, got.pv);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    row_t     rows[$];
    row_t     rw;
    request_t q;
    logic [63:0] k0;
    logic [63:0] kmax;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    shadow_gen     = 8'd0;
    foreach (shadow_table[i]) shadow_table[i] = '0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    mode_i       = 1'b0;
    search_key_i = '0;
    slot_i       = '0;
    new_value_i  = '0;
    new_eval_i   = '0;
    new_move_i   = '0;
    new_depth_i  = '0;
    new_bound_i  = '0;
    new_pv_i     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    k0   = 64'h0;
    kmax = 64'hFFFF_FFFF_FFFF_FFFF;
    // Directed table: empty probes, saturating depths, every bound, bad slot,
    // kept moves, shallow saves that lose, and a full cluster with victim pick.
    rows.push_back('{make_req(MODE_PROBE, k0, 0, 0, 0, 0, 0, 0, 0), 1,
                     make_res(0, 0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{make_req(MODE_PROBE, kmax, 0, 0, 0, 0, 0, 0, 0), 1,
                     make_res(0, 0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{make_req(MODE_SAVE, k0, 3, 16'h7FFF, 16'h8000, 16'hFFFF, 9'h0FF, 3, 1), 1,
                     make_res(0, 3, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{make_req(MODE_SAVE, k0, 0, 16'h7FFF, 16'h8000, 16'hFFFF, 9'h0FF, 3, 1), 1,
                     make_res(0, 0, 16'h7FFF, 16'h8000, 16'hFFFF, 8'd255, 3, 1)});
    rows.push_back('{make_req(MODE_PROBE, k0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, k0, 0, 16'h8000, 16'h7FFF, 0, 9'h100, 2, 0), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, k0, 0, 16'h1234, 16'h4321, 0, 9'h1F9, 1, 0), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, kmax, 0, 1, 2, 3, 9'h1FA, 0, 0), 1,
                     make_res(0, 0, 1, 2, 3, 8'd1, 0, 0)});
    rows.push_back('{make_req(MODE_SAVE, kmax, 1, 5, 6, 7, 9'd5, 2, 1), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, kmax, 2, 8, 9, 10, 9'd20, 1, 0), 0, '0});
    rows.push_back('{make_req(MODE_PROBE, kmax, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(MODE_PROBE, kmax - 64'd1, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, kmax, 2, 11, 12, 0, 9'd3, 2, 1), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, kmax, 2, 13, 14, 0, 9'd3, 3, 1), 0, '0});
    rows.push_back('{make_req(MODE_PROBE, 64'h5555_AAAA_5555_AAAA, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_req(MODE_SAVE, 64'hAAAA_5555_AAAA_5555, 1, 16'hAAAA, 16'h5555,
                              16'h5555, 9'h0AA, 2, 1), 0, '0});
    foreach (rows[i]) begin
      rw = rows[i];
      send_checked(rw.req, rw.fixed, rw.answer);
    end
    wait_drained();

    // Age changes the victim choice: step generations, with low bits set.
    write_generation(8'hFF);
    send_checked(make_req(MODE_PROBE, kmax - 64'd7, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    send_checked(make_req(MODE_PROBE, kmax, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    wait_drained();

    foreach (key_pool[i])
      key_pool[i] = {6'($urandom_range(3, 0)), 26'($urandom), $urandom};

    // Random phases with varying idling, result stalls and generations.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_generation(8'h00); end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  write_generation(8'h08); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; write_generation(8'h7D); end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; write_generation(8'hF8); end
        default: begin
          send_idle_pct = 0; recv_stall_pct = 0; write_generation(8'($urandom));
        end
      endcase
      if (phase == 4) hold_cycles = 60;
      for (int n = 0; n < 80; n++) begin
        q = random_request();
        send_checked(q, 0, '0);
      end
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
